// File: hdl/pixel_blend_unit_core_assert.svh
// Assertion macros shared by the blend unit; clocked on clk_i, off during reset.
`ifndef PIXEL_BLEND_UNIT_CORE_ASSERT_SVH
`define PIXEL_BLEND_UNIT_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define PBU_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pbu assertion failed");
`define PBU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pbu assertion failed");
`else
`define PBU_ASSERT_IMPLY(lbl, ante, cons)
`define PBU_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: hdl/pbu_pkg.sv
`timescale 1ns / 1ps
package pbu_pkg;

  localparam int unsigned NumLanes = 3;

  typedef enum logic [2:0] {
    OP_MULTIPLY = 3'd0,
    OP_SCREEN   = 3'd1,
    OP_SUBTRACT = 3'd2,
    OP_ADD      = 3'd3,
    OP_OVERLAY  = 3'd4,
    OP_SCALE    = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    CFG_ADD_RED    = 3'd0,
    CFG_ADD_GREEN  = 3'd1,
    CFG_ADD_BLUE   = 3'd2,
    CFG_GAIN_RED   = 3'd3,
    CFG_GAIN_GREEN = 3'd4,
    CFG_GAIN_BLUE  = 3'd5
  } cfg_idx_e;

  // How the second stage finishes a channel
  typedef enum logic [1:0] {
    KIND_DIV     = 2'd0,
    KIND_DIV_INV = 2'd1,
    KIND_SHIFT   = 2'd2,
    KIND_PASS    = 2'd3
  } kind_e;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] top_red;
    logic [7:0] top_green;
    logic [7:0] top_blue;
    logic [7:0] bottom_red;
    logic [7:0] bottom_green;
    logic [7:0] bottom_blue;
  } pbu_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } pbu_out_t;

endpackage

// File: hdl/pbu_lane.sv
`timescale 1ns / 1ps
module pbu_lane (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [2:0]  op_i,
  input  logic [7:0]  top_i,
  input  logic [7:0]  bottom_i,
  input  logic [7:0]  add_i,
  input  logic [15:0] gain_i,
  output logic [7:0]  res_o
);
  import pbu_pkg::*;

  logic [7:0]  mul_a;
  logic [15:0] mul_m;
  kind_e       kind_d, kind_q;
  logic [7:0]  pass_d, pass_q;
  logic [23:0] prod_d, prod_q;
  logic [8:0]  add_sum;

  logic [17:0] x;
  logic [18:0] est_sum;
  logic [10:0] q0;
  logic [18:0] q0_x255;
  logic [18:0] rem;
  logic [10:0] q;
  logic        q_big;

  // Stage 1: operand selection and the single 8x16 product
  always_comb begin
    mul_a   = top_i;
    mul_m   = {8'd0, bottom_i};
    kind_d  = KIND_PASS;
    pass_d  = 8'd0;
    add_sum = {1'b0, top_i} + {1'b0, add_i};
    case (op_i)
      OP_MULTIPLY: begin
        kind_d = KIND_DIV;
      end
      OP_SCREEN: begin
        mul_a  = ~top_i;
        mul_m  = {8'd0, ~bottom_i};
        kind_d = KIND_DIV_INV;
      end
      OP_SUBTRACT: begin
        pass_d = (bottom_i > top_i) ? (bottom_i - top_i) : 8'd0;
      end
      OP_ADD: begin
        pass_d = add_sum[8] ? 8'hFF : add_sum[7:0];
      end
      OP_OVERLAY: begin
        if (!bottom_i[7]) begin
          mul_m  = {7'd0, bottom_i, 1'b0};
          kind_d = KIND_DIV;
        end else begin
          mul_a  = ~top_i;
          mul_m  = {7'd0, ~bottom_i, 1'b0};
          kind_d = KIND_DIV_INV;
        end
      end
      OP_SCALE: begin
        mul_m  = gain_i;
        kind_d = KIND_SHIFT;
      end
      default: begin
        pass_d = 8'd0;
      end
    endcase
    prod_d = {16'd0, mul_a} * {8'd0, mul_m};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind_q <= kind_d;
      pass_q <= pass_d;
      prod_q <= prod_d;
    end
  end

  // Stage 2: rounded divide by 255 (estimate then one correction), or shift or pass per kind
  always_comb begin
    x       = prod_q[17:0] + 18'd127;
    est_sum = {1'b0, x} + {9'd0, x[17:8]};
    q0      = est_sum[18:8];
    q0_x255 = {q0, 8'd0} - {8'd0, q0};
    rem     = {1'b0, x} - q0_x255;
    q       = (rem >= 19'd255) ? (q0 + 11'd1) : q0;
    q_big   = |q[10:8];
    case (kind_q)
      KIND_DIV:     res_o = q_big ? 8'hFF : q[7:0];
      KIND_DIV_INV: res_o = q_big ? 8'h00 : (8'hFF - q[7:0]);
      KIND_SHIFT:   res_o = (|prod_q[23:16]) ? 8'hFF : prod_q[15:8];
      default:      res_o = pass_q;
    endcase
  end

endmodule

// File: hdl/pbu_merge.sv
`timescale 1ns / 1ps
module pbu_merge (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s1_valid_i,
  input  logic [7:0]      red_i,
  input  logic [7:0]      green_i,
  input  logic [7:0]      blue_i,
  output logic            adv_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pbu_pkg::pbu_out_t out_data_o
);
  import pbu_pkg::*;

  logic     valid_d, valid_q;
  pbu_out_t data_q;

  // Slot frees when empty or when its transfer completes this cycle
  assign adv_o   = !valid_q || out_ready_i;
  assign valid_d = adv_o ? s1_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && s1_valid_i) begin
      data_q <= '{out_red: red_i, out_green: green_i, out_blue: blue_i};
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// File: hdl/pixel_blend_unit_core.sv
`timescale 1ns / 1ps
// Three channel lanes each hold one 8x16 multiplier; an accepted input is registered in
// the product stage, then the output register. One pixel pair per cycle unless stalled.
// The input side keeps accepting while a result waits, as long as stage 1 is empty.
// Reset: asynchronous, active low; clears valid flags, offsets to 0 and gains to 1.0.
`include "pixel_blend_unit_core_assert.svh"
module pixel_blend_unit_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  pbu_pkg::pbu_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output pbu_pkg::pbu_out_t out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [2:0]       cfg_index_i,
  input  logic [15:0]      cfg_data_i
);
  import pbu_pkg::*;

  logic [NumLanes-1:0][7:0]  add_q;
  logic [NumLanes-1:0][15:0] gain_q;
  logic [NumLanes-1:0][7:0]  top_v;
  logic [NumLanes-1:0][7:0]  bot_v;
  logic [NumLanes-1:0][7:0]  res_v;
  logic                      s1_valid_d, s1_valid_q;
  logic                      s1_en;
  logic                      adv;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      add_q  <= '0;
      gain_q <= {NumLanes{16'd256}};
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ADD_RED:    add_q[0]  <= cfg_data_i[7:0];
        CFG_ADD_GREEN:  add_q[1]  <= cfg_data_i[7:0];
        CFG_ADD_BLUE:   add_q[2]  <= cfg_data_i[7:0];
        CFG_GAIN_RED:   gain_q[0] <= cfg_data_i;
        CFG_GAIN_GREEN: gain_q[1] <= cfg_data_i;
        CFG_GAIN_BLUE:  gain_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign top_v = {in_data_i.top_blue, in_data_i.top_green, in_data_i.top_red};
  assign bot_v = {in_data_i.bottom_blue, in_data_i.bottom_green, in_data_i.bottom_red};

  // Stage 1 loads when empty or when its item moves into the output register
  assign s1_en      = !s1_valid_q || adv;
  assign in_ready_o = s1_en;
  assign s1_valid_d = s1_en ? in_valid_i : s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    pbu_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (s1_en && in_valid_i),
      .op_i     (in_data_i.operation),
      .top_i    (top_v[g]),
      .bottom_i (bot_v[g]),
      .add_i    (add_q[g]),
      .gain_i   (gain_q[g]),
      .res_o    (res_v[g])
    );
  end

  pbu_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (s1_valid_q),
    .red_i       (res_v[0]),
    .green_i     (res_v[1]),
    .blue_i      (res_v[2]),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `PBU_ASSERT_IMPLY(a_full_blocks_input, s1_valid_q && out_valid_o && !out_ready_i, !in_ready_o)
  `PBU_ASSERT_NEXT(a_accept_fills_s1, in_valid_i && in_ready_o, s1_valid_q)
  `PBU_ASSERT_NEXT(a_s1_drains_to_out, s1_valid_q && (!out_valid_o || out_ready_i), out_valid_o)

endmodule

// File: sim/pbu_blend_check.sv
`timescale 1ns / 1ps
module pbu_blend_check (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  pbu_pkg::pbu_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  pbu_pkg::pbu_out_t out_data_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  output int unsigned       pending_o,
  output int unsigned       errors_o
);
  import pbu_pkg::*;

  logic [7:0]  offset_q [NumLanes];
  logic [15:0] gain_q   [NumLanes];
  pbu_out_t    blended_q [$];
  int unsigned fail_count;

  function automatic logic [7:0] blend_lane(logic [2:0] op, logic [7:0] t, logic [7:0] b,
                                            logic [7:0] offs, logic [15:0] g);
    int unsigned ti, bi, q, r;
    ti = t;
    bi = b;
    case (op)
      OP_MULTIPLY: r = (ti * bi + 127) / 255;
      OP_SCREEN: begin
        q = ((255 - ti) * (255 - bi) + 127) / 255;
        r = (q > 255) ? 0 : 255 - q;
      end
      OP_SUBTRACT: r = (bi > ti) ? bi - ti : 0;
      OP_ADD:      r = ti + offs;
      OP_OVERLAY: begin
        if (bi <= 127) begin
          r = (2 * ti * bi + 127) / 255;
        end else begin
          q = (2 * (255 - ti) * (255 - bi) + 127) / 255;
          r = (q > 255) ? 0 : 255 - q;
        end
      end
      OP_SCALE:    r = (ti * g) >> 8;
      default:     r = 0;  // unassigned codes give black
    endcase
    return (r > 255) ? 8'd255 : r[7:0];
  endfunction

  function automatic pbu_out_t blend_pixel(pbu_in_t px);
    pbu_out_t res;
    res.out_red   = blend_lane(px.operation, px.top_red, px.bottom_red, offset_q[0], gain_q[0]);
    res.out_green = blend_lane(px.operation, px.top_green, px.bottom_green,
                               offset_q[1], gain_q[1]);
    res.out_blue  = blend_lane(px.operation, px.top_blue, px.bottom_blue,
                               offset_q[2], gain_q[2]);
    return res;
  endfunction

  task automatic compare_lane(string lane, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, lane, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pbu_out_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NumLanes; i++) begin
        offset_q[i] = 8'd0;
        gain_q[i]   = 16'd256;
      end
      blended_q.delete();
      fail_count = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_ADD_RED:    offset_q[0] = cfg_data_i[7:0];
          CFG_ADD_GREEN:  offset_q[1] = cfg_data_i[7:0];
          CFG_ADD_BLUE:   offset_q[2] = cfg_data_i[7:0];
          CFG_GAIN_RED:   gain_q[0]   = cfg_data_i;
          CFG_GAIN_GREEN: gain_q[1]   = cfg_data_i;
          CFG_GAIN_BLUE:  gain_q[2]   = cfg_data_i;
          default: ;  // writes beyond the register file are dropped
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (blended_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, got %h", $time, out_data_i);
          fail_count++;
        end else begin
          want = blended_q.pop_front();
          compare_lane("out_red", want.out_red, out_data_i.out_red);
          compare_lane("out_green", want.out_green, out_data_i.out_green);
          compare_lane("out_blue", want.out_blue, out_data_i.out_blue);
        end
      end
      if (in_valid_i && in_ready_i) blended_q = {blended_q, blend_pixel(in_data_i)};
      pending_o <= blended_q.size();
      errors_o  <= fail_count;
    end
  end

endmodule

// File: sim/tb_pixel_blend_unit_core.sv
`timescale 1ns / 1ps
module tb_pixel_blend_unit_core;
  import pbu_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned LongHold   = 300;
  localparam int unsigned DrainTail  = 10;
  localparam logic [2:0]  OpUnusedLo  = 3'd6;
  localparam logic [2:0]  OpUnusedHi  = 3'd7;
  localparam logic [2:0]  CfgUnusedLo = 3'd6;
  localparam logic [2:0]  CfgUnusedHi = 3'd7;

  typedef enum int {SinkOpen, SinkCoin, SinkSparse, SinkToggle} sink_mode_e;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid;
  logic        in_ready;
  pbu_in_t     in_data;
  logic        out_valid;
  logic        out_ready;
  pbu_out_t    out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        hold_req;
  int unsigned pending;
  int unsigned errors;
  int unsigned burst_left;
  int unsigned cycles;

  pixel_blend_unit_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  pbu_blend_check u_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // output side: stretches of differing stall patterns, one long hold-off on request
  initial begin : sink
    sink_mode_e mode;
    int unsigned run;
    bit held;
    held = 1'b0;
    out_ready <= 1'b0;
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        repeat (LongHold) begin
          out_ready <= 1'b0;
          @(posedge clk);
        end
      end
      mode = sink_mode_e'($urandom_range(0, 3));
      run  = $urandom_range(1, 60);
      repeat (run) begin
        case (mode)
          SinkOpen:   out_ready <= 1'b1;
          SinkCoin:   out_ready <= ($urandom_range(0, 1) == 1);
          SinkSparse: out_ready <= ($urandom_range(0, 3) == 0);
          default:    out_ready <= ~out_ready;
        endcase
        @(posedge clk);
      end
    end
  end

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd127;
      3:       return 8'd128;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic pbu_in_t make_pixel(logic [2:0] op, logic [7:0] tr, logic [7:0] tg,
                                         logic [7:0] tb, logic [7:0] br, logic [7:0] bg,
                                         logic [7:0] bb);
    pbu_in_t px;
    px.operation    = op;
    px.top_red      = tr;
    px.top_green    = tg;
    px.top_blue     = tb;
    px.bottom_red   = br;
    px.bottom_green = bg;
    px.bottom_blue  = bb;
    return px;
  endfunction

  // valid stays up across back-to-back transfers; it only drops for a gap
  task automatic offer_pixel(pbu_in_t px);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic offer_random(int unsigned count);
    logic [2:0] op;
    repeat (count) begin
      if ($urandom_range(0, 15) < 14) op = 3'($urandom_range(0, 5));
      else op = ($urandom_range(0, 1) == 1) ? OpUnusedHi : OpUnusedLo;
      offer_pixel(make_pixel(op, pick_level(), pick_level(), pick_level(),
                             pick_level(), pick_level(), pick_level()));
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // offsets carry random upper bytes, which the block must drop
  task automatic set_blend_regs(logic [7:0] ar, logic [7:0] ag, logic [7:0] ab,
                                logic [15:0] gr, logic [15:0] gg, logic [15:0] gb);
    cfg_write(CFG_ADD_RED,    {8'($urandom), ar});
    cfg_write(CFG_ADD_GREEN,  {8'($urandom), ag});
    cfg_write(CFG_ADD_BLUE,   {8'($urandom), ab});
    cfg_write(CFG_GAIN_RED,   gr);
    cfg_write(CFG_GAIN_GREEN, gg);
    cfg_write(CFG_GAIN_BLUE,  gb);
  endtask

  initial begin : stimulus
    in_valid   <= 1'b0;
    in_data    <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= CFG_ADD_RED;
    cfg_data   <= '0;
    hold_req   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (!rst_n);

    // every code incl. the unassigned ones, lanes across the extremes and overlay threshold
    for (int code = 0; code < 8; code++) begin
      offer_pixel(make_pixel(3'(code), 8'd255, 8'd0, 8'd128, 8'd0, 8'd255, 8'd127));
      offer_pixel(make_pixel(3'(code), 8'd255, 8'd255, 8'd0, 8'd255, 8'd0, 8'd128));
    end
    offer_pixel(make_pixel(OP_OVERLAY, 8'd0, 8'd255, 8'd77, 8'd128, 8'd127, 8'd255));
    offer_pixel(make_pixel(OP_SCREEN, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    offer_pixel(make_pixel(OP_ADD, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0));
    offer_pixel(make_pixel(OP_SCALE, 8'd255, 8'd1, 8'd0, 8'd255, 8'd255, 8'd255));
    offer_pixel(make_pixel(OP_MULTIPLY, 8'd1, 8'd128, 8'd254, 8'd1, 8'd128, 8'd255));
    offer_random(80);
    drain_results();

    set_blend_regs(8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0);
    cfg_valid <= 1'b0;
    hold_req  <= 1'b1;
    offer_random(100);
    drain_results();

    set_blend_regs(8'd255, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    cfg_valid <= 1'b0;
    offer_random(100);
    drain_results();

    set_blend_regs(8'($urandom), 8'($urandom), 8'($urandom),
                   16'($urandom), 16'($urandom), 16'($urandom));
    cfg_write(CfgUnusedLo, 16'($urandom));
    cfg_write(CfgUnusedHi, 16'($urandom));
    cfg_valid <= 1'b0;
    offer_random(110);
    drain_results();

    set_blend_regs(8'd1, 8'd128, 8'd254, 16'd256, 16'd255, 16'd257);
    cfg_valid <= 1'b0;
    offer_random(110);
    drain_results();

    repeat (DrainTail) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
